// ----- hdl/isr_pkg.sv -----
`timescale 1ns / 1ps

package isr_pkg;

  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 16;
  localparam int WIDTH_DEF  = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ----- hdl/isr_if.sv -----
`timescale 1ns / 1ps

interface isr_in_if;
  logic                             valid;
  logic                             ready;
  logic [isr_pkg::RADICAND_W-1:0]   radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface isr_out_if;
  logic                         valid;
  logic                         ready;
  logic [isr_pkg::ROOT_W-1:0]   root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

// ----- hdl/isr_ctrl.sv -----
`timescale 1ns / 1ps

module isr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output isr_pkg::dp_cmd_t    cmd,
  input  isr_pkg::dp_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.step && !in_ready))
    else $error("search did not start after load");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && status.last) |=> out_valid)
    else $error("result not presented after final step");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("controller did not return to idle");

endmodule

// ----- hdl/isr_dp.sv -----
`timescale 1ns / 1ps

module isr_dp #(
  parameter int WIDTH = isr_pkg::WIDTH_DEF
) (
  input  logic                             clk,
  input  isr_pkg::dp_cmd_t                 cmd,
  output isr_pkg::dp_status_t              status,
  input  logic [isr_pkg::RADICAND_W-1:0]   radicand,
  output logic [isr_pkg::ROOT_W-1:0]       root
);

  // only the low bits of the field can matter
  localparam int EW = (WIDTH < isr_pkg::RADICAND_W) ? WIDTH : isr_pkg::RADICAND_W;
  localparam int RW = (EW + 1) / 2;
  localparam int PW = 2 * RW;

  logic [EW-1:0] v_r;
  logic [RW-1:0] root_r;
  logic [RW-1:0] bit_r;
  logic [RW-1:0] cand;
  logic [PW-1:0] sq;
  logic          fits;

  // trial root: set the current bit, keep it if its square still fits
  assign cand = root_r | bit_r;
  assign sq   = PW'(cand) * PW'(cand);
  assign fits = (sq <= PW'(v_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= radicand[EW-1:0];
      root_r <= '0;
      bit_r  <= RW'(1) << (RW - 1);
    end else if (cmd.step) begin
      if (fits) begin
        root_r <= cand;
      end
      bit_r <= bit_r >> 1;
    end
  end

  assign status.last = bit_r[0];
  assign root        = isr_pkg::ROOT_W'(root_r);

endmodule

// ----- hdl/integer_square_root_unit.sv -----
`timescale 1ns / 1ps

// Floor square root, one root bit resolved per cycle from the top down.
// An item is taken only in idle; the result is then held until out_ch takes
// it, and no new item is taken before that. The square-and-compare unit is
// used once per root bit.
// Reset: synchronous, active low; controller returns to idle, data is kept.
module integer_square_root_unit #(
  parameter int WIDTH = isr_pkg::WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  isr_in_if.sink     in_ch,
  isr_out_if.source  out_ch
);

  isr_pkg::dp_cmd_t    cmd;
  isr_pkg::dp_status_t status;

  // controller: idle -> run (one step per root bit) -> done (hold result)
  isr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: radicand, partial root and bit mask registers, one
  // half-width multiplier feeding a comparator; root register doubles
  // as the output register
  isr_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .status   (status),
    .radicand (in_ch.radicand),
    .root     (out_ch.root)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the floor square root unit.
// Items enter on the in_ch channel, one radicand each, and every accepted
// item produces exactly one root on out_ch. Roots are checked in order
// against a queue filled when each radicand is accepted.
module testbench;

  // The block is built with its default search width, so the bench uses
  // the same figure when it masks the radicand.
  localparam int SEARCH_W = isr_pkg::WIDTH_DEF;

  // Directed items plus the random ones; the last stretch runs with no
  // idling on either side.
  localparam int N_RANDOM     = 530;
  localparam int N_CALM_TAIL  = 60;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [isr_pkg::RADICAND_W-1:0] radicand;
    logic                           typed;   // expected root written in the row
    logic [isr_pkg::ROOT_W-1:0]     root;
  } sqrt_row_t;

  typedef struct {
    logic [isr_pkg::RADICAND_W-1:0] radicand;
    logic [isr_pkg::ROOT_W-1:0]     root;
  } root_expect_t;

  logic clk;
  logic rst_n;

  isr_in_if  in_ch ();
  isr_out_if out_ch ();

  integer_square_root_unit #(
    .WIDTH (SEARCH_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  root_expect_t roots_due[$];
  int           mismatches;
  logic         idling_on;

  // Directed rows: zero (empty search range), one, the first few roots,
  // perfect squares and their neighbours at both ends of the field, the
  // largest radicand and alternating bit patterns.
  sqrt_row_t directed_rows[] = '{
    '{32'h0000_0000, 1'b1, 16'd0},
    '{32'h0000_0001, 1'b1, 16'd1},
    '{32'h0000_0002, 1'b1, 16'd1},
    '{32'h0000_0003, 1'b1, 16'd1},
    '{32'h0000_0004, 1'b1, 16'd2},
    '{32'h0000_0008, 1'b1, 16'd2},
    '{32'h0000_0009, 1'b1, 16'd3},
    '{32'h0000_0010, 1'b1, 16'd4},
    '{32'h0000_FFFF, 1'b1, 16'd255},
    '{32'h0001_0000, 1'b1, 16'd256},
    '{32'hFFFF_FFFF, 1'b1, 16'd65535},
    '{32'hFFFE_0001, 1'b1, 16'd65535},
    '{32'hFFFE_0000, 1'b1, 16'd65534},
    '{32'h8000_0000, 1'b1, 16'd46340},
    '{32'h7FFF_FFFF, 1'b1, 16'd46340},
    '{32'hAAAA_AAAA, 1'b0, 16'd0},
    '{32'h5555_5555, 1'b0, 16'd0},
    '{32'hFFFF_0000, 1'b0, 16'd0},
    '{32'h0000_FFFE, 1'b0, 16'd0},
    '{32'h1234_5678, 1'b0, 16'd0},
    '{32'hFFFF_FFFE, 1'b0, 16'd0}
  };

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Floor square root, resolved one root bit at a time from the top down;
  // the square is taken at 64 bits so it cannot wrap.
  function automatic logic [isr_pkg::ROOT_W-1:0] floor_sqrt(
    logic [isr_pkg::RADICAND_W-1:0] v
  );
    logic [63:0] val;
    logic [63:0] sq;
    logic [31:0] r;
    logic [31:0] trial;
    val = 64'(v);
    if (SEARCH_W < isr_pkg::RADICAND_W) val = val & ((64'd1 << SEARCH_W) - 64'd1);
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      sq = 64'(trial) * 64'(trial);
      if (sq <= val) r = trial;
    end
    // Wide builds would wrap here; the root field keeps the low bits.
    return r[isr_pkg::ROOT_W-1:0];
  endfunction

  // Random radicands, weighted towards the edges of each root step:
  // exact squares, one below a square, the top of a step, small values
  // and values with many leading zeros, as well as plain random words.
  function automatic logic [isr_pkg::RADICAND_W-1:0] pick_radicand();
    logic [31:0] r;
    logic [31:0] word;
    r    = $urandom_range(0, 65535);
    word = $urandom;
    case ($urandom_range(0, 5))
      0: return word;
      1: return r * r;
      2: return r * r - 32'd1;     // wraps to all ones when r is zero
      3: return r * r + 2 * r;     // just below the next square
      4: return $urandom_range(0, 1023);
      default: return word >> $urandom_range(0, 31);
    endcase
  endfunction

  // Offer one item from the falling edge and hold it until it is taken.
  task automatic offer_radicand(input logic [isr_pkg::RADICAND_W-1:0] v,
                                input logic typed,
                                input logic [isr_pkg::ROOT_W-1:0] root);
    root_expect_t e;
    e.radicand = v;
    e.root     = typed ? root : floor_sqrt(v);
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The item went in at this edge; its root is now due.
    roots_due.push_back(e);
  endtask

  // Sender gap: valid low and the payload scrambled.
  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 8);
    @(negedge clk);
    in_ch.valid    <= 1'b0;
    in_ch.radicand <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (idling_on && $urandom_range(0, 3) == 0) sender_gap();
  endtask

  // Stimulus
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.radicand = '0;
    idling_on      = 1'b1;
    mismatches     = 0;

    // Reset held low, then released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_radicand(directed_rows[i].radicand, directed_rows[i].typed,
                     directed_rows[i].root);
      maybe_gap();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // A stretch without idling in the middle of the run.
      if (i == 200) idling_on = 1'b0;
      if (i == 260) idling_on = 1'b1;
      // Let the block go fully idle once, then restart from empty.
      if (i == 300) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (roots_due.size() != 0) @(negedge clk);
      end
      // Calm tail: back to back items, receiver always ready.
      if (i == N_RANDOM - N_CALM_TAIL) idling_on = 1'b0;
      offer_radicand(pick_radicand(), 1'b0, '0);
      maybe_gap();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for every root still due, then a little longer for strays.
    while (roots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: ready low in random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker: each root taken is compared with the oldest one due.
  always @(posedge clk) begin
    root_expect_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (roots_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected root: expected none, got %0d", $time, out_ch.root);
      end else begin
        e = roots_due.pop_front();
        if (out_ch.root !== e.root) begin
          mismatches++;
          $display("%0t: root of %h: expected %0d, got %0d",
                   $time, e.radicand, e.root, out_ch.root);
        end
      end
    end
  end

  // Watchdog, far beyond the slowest correct run (about 200 us of items
  // with every gap and stall at its longest).
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
